// ===== src/bouncing_ball_pixel_generator_unit_macros.svh =====
// Assertion macros for the bouncing ball pixel generator.
// Included by the top level; each macro expects clk and rst_n in scope.
`ifndef BOUNCING_BALL_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define BOUNCING_BALL_PIXEL_GENERATOR_UNIT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define BBP_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define BBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bbp_pkg.sv =====
// Shared types, constants and helper functions of the bouncing ball pixel generator.
// No dependencies; the front end, back end and top level refer to it by scoped names.
`timescale 1ns / 1ps
package bbp_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 10;

  localparam int SIZE_W   = 10;
  localparam int COLOUR_W = 16;
  localparam int IDX_W    = 3;
  localparam int MIN_SIZE = 16;

  // Division of a 10-bit size by five as a multiply and shift.
  localparam int DIV5_MUL = 205;
  localparam int DIV5_SH  = 10;

  localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST   = 10'd320;
  localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST  = 10'd240;
  localparam logic [COLOUR_W-1:0] BALL_COLOUR_A_RST = 16'd63488;
  localparam logic [COLOUR_W-1:0] BALL_COLOUR_B_RST = 16'd65535;
  localparam logic [COLOUR_W-1:0] LIGHT_GREY_RST    = 16'd50712;
  localparam logic [COLOUR_W-1:0] MID_GREY_RST      = 16'd25388;
  localparam logic [COLOUR_W-1:0] DARK_GREY_RST     = 16'd12678;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_BALL_COLOUR_A = 3'd2,
    REG_BALL_COLOUR_B = 3'd3,
    REG_LIGHT_GREY    = 3'd4,
    REG_MID_GREY      = 3'd5,
    REG_DARK_GREY     = 3'd6
  } reg_idx_t;

  typedef logic signed [15:0] s16_t;
  typedef logic signed [31:0] s32_t;
  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic [COLOUR_W-1:0] ball_colour_a;
    logic [COLOUR_W-1:0] ball_colour_b;
    logic [COLOUR_W-1:0] light_grey;
    logic [COLOUR_W-1:0] mid_grey;
    logic [COLOUR_W-1:0] dark_grey;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIVG, ST_DIVH, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
    ST_M7, ST_M8, ST_M9, ST_SQRT, ST_DIVQ, ST_PAR, ST_U1, ST_U2, ST_U3, ST_OUT
  } bk_state_t;

  localparam s32_t S32_MAX = 32'sh7FFFFFFF;
  localparam s32_t S32_MIN = 32'sh80000000;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    return (v < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) : v;
  endfunction

  function automatic s32_t sat32(input s64_t v);
    s32_t r;
    if (v > s64_t'(S32_MAX)) r = S32_MAX;
    else if (v < s64_t'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic s32_t sat_mag(input logic [63:0] mag, input logic neg);
    s32_t r;
    if (!neg) r = (mag > 64'h7FFFFFFF) ? S32_MAX : s32_t'(mag[31:0]);
    else r = (mag >= 64'h80000000) ? S32_MIN : -s32_t'(mag[31:0]);
    return r;
  endfunction

endpackage

// ===== src/bbp_fifo.sv =====
// Two-entry queue between the raster front end and the shading back end.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps
module bbp_fifo #(
  parameter int WIDTH = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             not_empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rdata     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== src/bbp_front.sv =====
// Raster front end: accepts request beats, applies restart and walks the cursor.
// Uses bbp_pkg for the configuration type and size clamping.
`timescale 1ns / 1ps
module bbp_front #(
  parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bbp_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  input  logic                  q_full,
  output logic                  push,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y,
  output logic                  last
);

  logic [COORD_BITS-1:0]     col_r, col_nxt, row_r, row_nxt;
  logic [COORD_BITS-1:0]     ncol, nrow;
  logic [bbp_pkg::SIZE_W-1:0] effw, effh;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    effw    = bbp_pkg::eff_size(cfg.frame_width);
    effh    = bbp_pkg::eff_size(cfg.frame_height);
    x       = in_restart ? '0 : col_r;
    y       = in_restart ? '0 : row_r;
    ncol    = x + COORD_BITS'(1);
    nrow    = y + COORD_BITS'(1);
    last    = 1'b0;
    col_nxt = ncol;
    row_nxt = y;
    if (ncol == '0 || 32'(ncol) >= 32'(effw)) begin
      col_nxt = '0;
      row_nxt = nrow;
      if (nrow == '0 || 32'(nrow) >= 32'(effh)) begin
        row_nxt = '0;
        last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== src/bbp_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by the shading back end for every quotient but the height over five.
`timescale 1ns / 1ps
module bbp_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    q_r, q_nxt;
  logic [DW:0]      rem_r, rem_nxt, trial;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic             ge;

  assign done = done_r;
  assign quo  = q_r;

  always_comb begin
    trial   = {rem_r[DW-1:0], q_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? trial - {1'b0, den_r} : trial;
    q_nxt   = {q_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== src/bbp_back.sv =====
// Shading back end: renders one queued pixel with a shared multiplier, the divider
// and a bit-pair square root, then advances the animation after a frame's last pixel.
// Depends on bbp_pkg and bbp_div.
`timescale 1ns / 1ps
module bbp_back #(
  parameter int FRAC_BITS  = bbp_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bbp_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  input  logic                  q_last,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_pixel_colour,
  output logic                  out_frame_last,
  output bbp_pkg::bk_stat_t     stat
);

  localparam bbp_pkg::s64_t ONE   = 64'sd1 <<< FRAC_BITS;
  localparam bbp_pkg::s64_t C954  = ((64'sd954 <<< FRAC_BITS) * 2 + 1000) / 2000;
  localparam bbp_pkg::s64_t C3    = ((64'sd3 <<< FRAC_BITS) * 2 + 10) / 20;
  localparam bbp_pkg::s64_t C06   = ((64'sd6 <<< FRAC_BITS) * 2 + 10) / 20;
  localparam bbp_pkg::s64_t C09   = ((64'sd9 <<< FRAC_BITS) * 2 + 100) / 200;
  localparam bbp_pkg::s64_t C04   = ((64'sd4 <<< FRAC_BITS) * 2 + 100) / 200;
  localparam bbp_pkg::s64_t C002  = ((64'sd2 <<< FRAC_BITS) * 2 + 1000) / 2000;
  localparam bbp_pkg::s64_t C175  = ((64'sd7 <<< FRAC_BITS) * 2 + 4) / 8;
  localparam bbp_pkg::s64_t C01   = ((64'sd1 <<< FRAC_BITS) * 2 + 10) / 20;
  localparam bbp_pkg::s64_t C001  = ((64'sd1 <<< FRAC_BITS) * 2 + 100) / 200;
  localparam bbp_pkg::s32_t CX_RST =
    bbp_pkg::sat32(64'(bbp_pkg::FRAME_WIDTH_RST / 2) <<< FRAC_BITS);
  localparam bbp_pkg::s32_t CY_RST =
    bbp_pkg::sat32(64'(bbp_pkg::FRAME_HEIGHT_RST / 4) <<< FRAC_BITS);
  localparam bbp_pkg::s32_t VX_RST =
    bbp_pkg::sat32(C001 * 64'(bbp_pkg::FRAME_WIDTH_RST));
  localparam bbp_pkg::s32_t RATE_RST = bbp_pkg::sat32(C01);
  localparam logic [63:0] BIT_TOP = 64'd1 << 62;

  bbp_pkg::bk_state_t st_r, st_nxt;

  logic [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic                  last_r, last_nxt;
  bbp_pkg::s32_t         g_r, g_nxt, h_r, h_nxt, f_r, f_nxt, a_r, a_nxt, hh_r, hh_nxt;
  bbp_pkg::s64_t         num_r, num_nxt, prod_r, prod_nxt;
  logic                  inside_r, inside_nxt, neg_r, neg_nxt;
  logic [15:0]           colour_r, colour_nxt;
  logic [63:0]           sqv_r, sqv_nxt, sqres_r, sqres_nxt, sqbit_r, sqbit_nxt;
  bbp_pkg::s32_t         spin_r, spin_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  bbp_pkg::s32_t         vx_r, vx_nxt, vy_r, vy_nxt, rate_r, rate_nxt;
  logic                  ov_r, ov_nxt, ofl_r, ofl_nxt;
  logic [15:0]           opx_r, opx_nxt;

  bbp_pkg::s32_t         mul_a, mul_b, fm;
  logic                  div_start, div_done;
  logic [63:0]           div_num, div_quo, sq_sum;
  logic [31:0]           div_den;
  logic [9:0]            effw, effh;
  logic [18:0]           hmul;
  logic [7:0]            h5;
  bbp_pkg::s16_t         sx, sy, sw, sh, sfs, sr;
  bbp_pkg::s64_t         nval, t1, t2, xr, thr;
  logic [15:0]           outc;
  logic                  shadow, par, slot_free;

  bbp_div #(.NW(64), .DW(32)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid        = ov_r;
  assign out_pixel_colour = opx_r;
  assign out_frame_last   = ofl_r;
  assign slot_free        = !ov_r || out_ready;

  always_comb begin
    effw = bbp_pkg::eff_size(cfg.frame_width);
    effh = bbp_pkg::eff_size(cfg.frame_height);
    hmul = 19'(effh) * 19'(bbp_pkg::DIV5_MUL);
    h5   = hmul[bbp_pkg::DIV5_SH +: 8];
    sw   = bbp_pkg::s16_t'(effw);
    sh   = bbp_pkg::s16_t'(effh);
    sr   = bbp_pkg::s16_t'(h5) + bbp_pkg::s16_t'(effh[0]) + 16'sd1;
    sfs  = bbp_pkg::s16_t'(h5) - 16'sd1;
    sx   = bbp_pkg::s16_t'(x_r);
    sy   = bbp_pkg::s16_t'(y_r);
    fm   = bbp_pkg::sat32(prod_r >>> FRAC_BITS);
    sq_sum = sqres_r + sqbit_r;
  end

  // Multiplier operands: the product is registered in prod_r and read back as fm.
  always_comb begin
    mul_a = g_r;
    mul_b = g_r;
    case (st_r)
      bbp_pkg::ST_M1: begin mul_a = bbp_pkg::s32_t'(C954); mul_b = h_r; end
      bbp_pkg::ST_M2: begin mul_a = bbp_pkg::s32_t'(C3);   mul_b = g_r; end
      bbp_pkg::ST_M3: begin mul_a = g_r; mul_b = g_r; end
      bbp_pkg::ST_M4: begin mul_a = h_r; mul_b = h_r; end
      bbp_pkg::ST_M5: begin mul_a = f_r; mul_b = f_r; end
      bbp_pkg::ST_M6: begin mul_a = bbp_pkg::s32_t'(C954); mul_b = g_r; end
      bbp_pkg::ST_M7: begin mul_a = bbp_pkg::s32_t'(C3);   mul_b = h_r; end
      bbp_pkg::ST_M8: begin
        mul_a = g_r;
        mul_b = bbp_pkg::sat32(64'(g_r) + C06);
      end
      default: begin mul_a = g_r; mul_b = g_r; end
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      bbp_pkg::ST_IDLE: if (q_valid) st_nxt = bbp_pkg::ST_DIVG;
      bbp_pkg::ST_DIVG: if (div_done) st_nxt = bbp_pkg::ST_DIVH;
      bbp_pkg::ST_DIVH: if (div_done) st_nxt = bbp_pkg::ST_M1;
      bbp_pkg::ST_M1:   st_nxt = bbp_pkg::ST_M2;
      bbp_pkg::ST_M2:   st_nxt = bbp_pkg::ST_M3;
      bbp_pkg::ST_M3:   st_nxt = bbp_pkg::ST_M4;
      bbp_pkg::ST_M4:   st_nxt = bbp_pkg::ST_M5;
      bbp_pkg::ST_M5:   st_nxt = bbp_pkg::ST_M6;
      bbp_pkg::ST_M6:   st_nxt = bbp_pkg::ST_M7;
      bbp_pkg::ST_M7:   st_nxt = bbp_pkg::ST_M8;
      bbp_pkg::ST_M8:   st_nxt = bbp_pkg::ST_M9;
      bbp_pkg::ST_M9: begin
        if (inside_r) st_nxt = bbp_pkg::ST_SQRT;
        else st_nxt = last_r ? bbp_pkg::ST_U1 : bbp_pkg::ST_OUT;
      end
      bbp_pkg::ST_SQRT: begin
        if (sqbit_r == '0) st_nxt = (sqres_r == '0) ? bbp_pkg::ST_PAR : bbp_pkg::ST_DIVQ;
      end
      bbp_pkg::ST_DIVQ: if (div_done) st_nxt = bbp_pkg::ST_PAR;
      bbp_pkg::ST_PAR:  st_nxt = last_r ? bbp_pkg::ST_U1 : bbp_pkg::ST_OUT;
      bbp_pkg::ST_U1:   st_nxt = bbp_pkg::ST_U2;
      bbp_pkg::ST_U2:   st_nxt = bbp_pkg::ST_U3;
      bbp_pkg::ST_U3:   st_nxt = bbp_pkg::ST_OUT;
      bbp_pkg::ST_OUT:  if (slot_free) st_nxt = bbp_pkg::ST_IDLE;
      default: st_nxt = bbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; last_nxt = last_r;
    g_nxt = g_r; h_nxt = h_r; f_nxt = f_r; a_nxt = a_r; hh_nxt = hh_r;
    num_nxt = num_r; inside_nxt = inside_r; neg_nxt = neg_r; colour_nxt = colour_r;
    sqv_nxt = sqv_r; sqres_nxt = sqres_r; sqbit_nxt = sqbit_r;
    spin_nxt = spin_r; cx_nxt = cx_r; cy_nxt = cy_r;
    vx_nxt = vx_r; vy_nxt = vy_r; rate_nxt = rate_r;
    ov_nxt = ov_r && !out_ready; opx_nxt = opx_r; ofl_nxt = ofl_r;
    q_pop = 1'b0; div_start = 1'b0; div_num = '0; div_den = 32'(sr);
    nval = '0; t1 = '0; t2 = '0; xr = '0; thr = '0; outc = '0;
    shadow = 1'b0; par = 1'b0;
    case (st_r)
      bbp_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          x_nxt     = q_x;
          y_nxt     = q_y;
          last_nxt  = q_last;
          nval      = 64'(cx_r) - (64'(q_x) <<< FRAC_BITS);
          neg_nxt   = nval < 0;
          div_num   = (nval < 0) ? 64'(-nval) : 64'(nval);
          div_start = 1'b1;
        end
      end
      bbp_pkg::ST_DIVG: begin
        if (div_done) begin
          g_nxt     = bbp_pkg::sat_mag(div_quo, neg_r);
          nval      = 64'(cy_r) - (64'(y_r) <<< FRAC_BITS);
          neg_nxt   = nval < 0;
          div_num   = (nval < 0) ? 64'(-nval) : 64'(nval);
          div_start = 1'b1;
        end
      end
      bbp_pkg::ST_DIVH: if (div_done) h_nxt = bbp_pkg::sat_mag(div_quo, neg_r);
      bbp_pkg::ST_M2:   a_nxt = fm;
      bbp_pkg::ST_M3:   f_nxt = bbp_pkg::sat32(64'(a_r) - 64'(fm));
      bbp_pkg::ST_M4:   a_nxt = fm;
      bbp_pkg::ST_M5: begin
        hh_nxt     = fm;
        inside_nxt = (64'(a_r) + 64'(fm)) < ONE;
      end
      bbp_pkg::ST_M6:   a_nxt = fm;
      bbp_pkg::ST_M7:   num_nxt = 64'(fm);
      bbp_pkg::ST_M8:   num_nxt = num_r + 64'(fm);
      bbp_pkg::ST_M9: begin
        shadow = (64'(fm) + C09 + 64'(hh_r)) < ONE;
        xr     = ONE - 64'(a_r);
        if (inside_r) begin
          sqv_nxt   = (xr > 0) ? (64'(xr) << FRAC_BITS) : '0;
          sqres_nxt = '0;
          sqbit_nxt = BIT_TOP;
        end else begin
          outc = (sx < sfs || sx > sw - sfs) ? cfg.dark_grey : cfg.light_grey;
          if (sy > sh - sfs) begin
            outc = (sx < sh - sy || sh - sy > sw - sx) ? cfg.dark_grey : cfg.mid_grey;
          end
          colour_nxt = shadow ? (outc >> 1) : outc;
        end
      end
      bbp_pkg::ST_SQRT: begin
        if (sqbit_r != '0) begin
          if (sqv_r >= sq_sum) begin
            sqv_nxt   = sqv_r - sq_sum;
            sqres_nxt = (sqres_r >> 1) + sqbit_r;
          end else begin
            sqres_nxt = sqres_r >> 1;
          end
          sqbit_nxt = sqbit_r >> 2;
        end else if (sqres_r == '0) begin
          a_nxt = (num_r > 0) ? bbp_pkg::S32_MAX :
                  ((num_r < 0) ? bbp_pkg::S32_MIN : '0);
        end else begin
          neg_nxt   = num_r < 0;
          div_num   = ((num_r < 0) ? 64'(-num_r) : 64'(num_r)) << FRAC_BITS;
          div_den   = sqres_r[31:0];
          div_start = 1'b1;
        end
      end
      bbp_pkg::ST_DIVQ: if (div_done) a_nxt = bbp_pkg::sat_mag(div_quo, neg_r);
      bbp_pkg::ST_PAR: begin
        t1  = 9 * ONE - 64'(spin_r) + 64'(a_r);
        t2  = 2 * ONE + 2 * 64'(f_r);
        t1  = (t1 < 0) ? -t1 : t1;
        t2  = (t2 < 0) ? -t2 : t2;
        par = t1[FRAC_BITS] ^ t2[FRAC_BITS];
        colour_nxt = par ? cfg.ball_colour_b : cfg.ball_colour_a;
      end
      bbp_pkg::ST_U1: begin
        spin_nxt = spin_r + rate_r;
        cy_nxt   = bbp_pkg::sat32(64'(cy_r) + 64'(vy_r));
      end
      bbp_pkg::ST_U2: begin
        thr = 64'(bbp_pkg::sat32((64'(sh) <<< FRAC_BITS) - C175 * 64'(sfs)));
        if (64'(cy_r) > thr) vy_nxt = bbp_pkg::sat32(-(C04 * 64'(sh)));
        else vy_nxt = bbp_pkg::sat32(64'(vy_r) + C002 * 64'(sh));
        cx_nxt = bbp_pkg::sat32(64'(cx_r) + 64'(vx_r));
      end
      bbp_pkg::ST_U3: begin
        if (cx_r < bbp_pkg::sat32(64'(sr) <<< FRAC_BITS) ||
            cx_r > bbp_pkg::sat32(64'(sw - sr) <<< FRAC_BITS)) begin
          rate_nxt = bbp_pkg::sat32(-64'(rate_r));
          vx_nxt   = bbp_pkg::sat32(-64'(vx_r));
        end
      end
      bbp_pkg::ST_OUT: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          opx_nxt = colour_r;
          ofl_nxt = last_r;
        end
      end
      default: ;
    endcase
  end

  assign stat.busy = (st_r != bbp_pkg::ST_IDLE);
  assign stat.pop  = q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= bbp_pkg::ST_IDLE;
      ov_r   <= 1'b0;
      spin_r <= '0;
      cx_r   <= CX_RST;
      cy_r   <= CY_RST;
      vx_r   <= VX_RST;
      vy_r   <= '0;
      rate_r <= RATE_RST;
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      spin_r <= spin_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      rate_r <= rate_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; last_r <= last_nxt;
    g_r <= g_nxt; h_r <= h_nxt; f_r <= f_nxt; a_r <= a_nxt; hh_r <= hh_nxt;
    num_r <= num_nxt; prod_r <= prod_nxt; inside_r <= inside_nxt; neg_r <= neg_nxt;
    colour_r <= colour_nxt;
    sqv_r <= sqv_nxt; sqres_r <= sqres_nxt; sqbit_r <= sqbit_nxt;
    opx_r <= opx_nxt; ofl_r <= ofl_nxt;
  end

endmodule

// ===== src/bouncing_ball_pixel_generator_unit.sv =====
// Top level of the bouncing ball pixel generator: configuration registers,
// raster front end, queue and shading back end. Depends on bbp_pkg and all bbp_ modules.
//
// Usage: every request beat on the in_ channel (in_restart moves the cursor to the
// origin first) yields one result beat on the out_ channel carrying the RGB565 colour
// of the pixel under the cursor, in raster order; out_frame_last marks the last pixel
// of a frame, after which the animation has moved on. Registers are written through
// the cfg_ channel (index, data), which is always ready; write them only while idle.
// Each pixel passes through the shared 64-bit divider, which yields one quotient bit a
// cycle, and a pixel inside the ball also through the 32-step square root; a frame's
// last pixel also passes through the animation update states ST_U1 to ST_U3.
// Pixels are shaded one at a time; the front end queues up to two requests ahead.
// A result waits in the output register while the receiver stalls, and the back end
// meanwhile starts on the next pixel. Reset restores the register defaults, puts the
// cursor at the origin and returns the ball to its starting position and motion.
`timescale 1ns / 1ps
`include "bouncing_ball_pixel_generator_unit_macros.svh"
module bouncing_ball_pixel_generator_unit #(
  parameter int FRAC_BITS  = bbp_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bbp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_pixel_colour,
  output logic                        out_frame_last
);

  localparam int QW = 2 * COORD_BITS + 1;

  bbp_pkg::cfg_t         cfg_r, cfg_nxt;
  bbp_pkg::bk_stat_t     bk_stat;
  logic                  push, q_full, q_valid, q_pop, f_last;
  logic [COORD_BITS-1:0] f_x, f_y;
  logic [QW-1:0]         q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        bbp_pkg::REG_FRAME_WIDTH:   cfg_nxt.frame_width   = cfg_data[9:0];
        bbp_pkg::REG_FRAME_HEIGHT:  cfg_nxt.frame_height  = cfg_data[9:0];
        bbp_pkg::REG_BALL_COLOUR_A: cfg_nxt.ball_colour_a = cfg_data;
        bbp_pkg::REG_BALL_COLOUR_B: cfg_nxt.ball_colour_b = cfg_data;
        bbp_pkg::REG_LIGHT_GREY:    cfg_nxt.light_grey    = cfg_data;
        bbp_pkg::REG_MID_GREY:      cfg_nxt.mid_grey      = cfg_data;
        bbp_pkg::REG_DARK_GREY:     cfg_nxt.dark_grey     = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= bbp_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height  <= bbp_pkg::FRAME_HEIGHT_RST;
      cfg_r.ball_colour_a <= bbp_pkg::BALL_COLOUR_A_RST;
      cfg_r.ball_colour_b <= bbp_pkg::BALL_COLOUR_B_RST;
      cfg_r.light_grey    <= bbp_pkg::LIGHT_GREY_RST;
      cfg_r.mid_grey      <= bbp_pkg::MID_GREY_RST;
      cfg_r.dark_grey     <= bbp_pkg::DARK_GREY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bbp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .q_full     (q_full),
    .push       (push),
    .x          (f_x),
    .y          (f_y),
    .last       (f_last)
  );

  bbp_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     ({f_x, f_y, f_last}),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_valid)
  );

  bbp_back #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_x              (q_rdata[QW-1 -: COORD_BITS]),
    .q_y              (q_rdata[COORD_BITS:1]),
    .q_last           (q_rdata[0]),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_colour (out_pixel_colour),
    .out_frame_last   (out_frame_last),
    .stat             (bk_stat)
  );

  `BBP_ASSERT_NOW(a_pop_needs_entry, bk_stat.pop |-> q_valid, "back end popped an empty queue")
  `BBP_ASSERT_NEXT(a_pop_starts_work, bk_stat.pop, bk_stat.busy, "popped pixel was not started")
  `BBP_ASSERT_NOW(a_pop_only_idle, bk_stat.pop |-> !bk_stat.busy, "pop while a pixel is in work")

endmodule
